### rtl/placement_contact_scorer_core_assert.svh
// assertion macros for the placement contact scorer
`ifndef PLACEMENT_CONTACT_SCORER_CORE_ASSERT_SVH
`define PLACEMENT_CONTACT_SCORER_CORE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define PCS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define PCS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/pcs_pkg.sv
// ---------------------------------------------------------------------------
// pcs_pkg
// shared types, constants and helpers of the placement contact scorer
// ---------------------------------------------------------------------------
package pcs_pkg;

    localparam int MAX_BOXES_DEF = 64;
    localparam int CW = 12;
    localparam int AREA_W = 27;
    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

    localparam logic [CW-1:0] WIDTH_RST  = 12'd1200;
    localparam logic [CW-1:0] DEPTH_RST  = 12'd800;
    localparam logic [CW-1:0] HEIGHT_RST = 12'd1000;
    localparam logic [CW-1:0] GAP_RST    = 12'd40;

    // register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_DEPTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_GAP    = 2'd3;

    localparam logic KIND_CLEAR = 1'b0;
    localparam logic KIND_PLACE = 1'b1;

    typedef struct packed {
        logic [CW-1:0] x, y, z, w, d, h;
    } box_t;

    typedef struct packed {
        logic [CW-1:0] width, depth, height, gap;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_WALL, ST_SCAN, ST_DRAIN, ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic wall;
        logic scan;
        logic store;
        logic clear;
        logic reject;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_clear;
        logic full;
        logic scan_last;
        logic scan_busy;
        logic empty;
    } stat_t;

    typedef struct packed {
        logic [AREA_W-1:0] wall_area;
        logic [AREA_W-1:0] item_area;
        logic [2:0] walls_touched;
        logic [12:0] height_gap;
        logic neighbour_found;
        logic store_full;
    } res_t;

    // length of overlap of two ranges
    function automatic logic [12:0] ov_len(logic [12:0] a0, logic [12:0] a1,
                                           logic [12:0] b0, logic [12:0] b1);
        logic [12:0] lo, hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = (a1 < b1) ? a1 : b1;
        return (hi > lo) ? hi - lo : 13'd0;
    endfunction

    // gap between two ranges
    function automatic logic [12:0] gap_len(logic [12:0] a0, logic [12:0] a1,
                                            logic [12:0] b0, logic [12:0] b1);
        if (a1 <= b0) return b0 - a1;
        if (b1 <= a0) return a0 - b1;
        return 13'd0;
    endfunction

endpackage

### rtl/placement_contact_scorer_core.sv
// input transfer to result: a clear or rejected item goes from the wall check
// straight to the result; a placement into an empty store skips the scan, else
// all stored boxes are read (one store read per cycle, two stage pipeline
// drained first); one item at a time, next accepted once the result is taken
// reset: aresetn synchronous active low; store emptied, registers to defaults
// ---------------------------------------------------------------------------
// placement_contact_scorer_core
// scores wall and face contact of each new box and appends it to the store
// ---------------------------------------------------------------------------
module placement_contact_scorer_core #(
    parameter int MAX_BOXES = pcs_pkg::MAX_BOXES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, size_w, size_d, size_h
    input  logic [71:0]  s_tdata,
    // kind
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // wall_area, item_area, walls_touched, height_gap, neighbour_found,
    // store_full, zero fill
    output logic [79:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    pcs_pkg::cfg_t cfg_reg;
    pcs_pkg::cmd_t cmd;
    pcs_pkg::stat_t stat;
    pcs_pkg::res_t res;
    pcs_pkg::box_t in_box;
    logic [1:0] ridx;

    assign pready = 1'b1;
    assign ridx = paddr[3:2];

    // config register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= {pcs_pkg::WIDTH_RST, pcs_pkg::DEPTH_RST,
                        pcs_pkg::HEIGHT_RST, pcs_pkg::GAP_RST};
        end else if (psel && penable && pwrite) begin
            unique case (ridx)
                pcs_pkg::REG_WIDTH:  cfg_reg.width  <= pwdata[11:0];
                pcs_pkg::REG_DEPTH:  cfg_reg.depth  <= pwdata[11:0];
                pcs_pkg::REG_HEIGHT: cfg_reg.height <= pwdata[11:0];
                default:             cfg_reg.gap    <= pwdata[11:0];
            endcase
        end
    end

    // config read back
    always_comb begin
        unique case (ridx)
            pcs_pkg::REG_WIDTH:  prdata = {20'd0, cfg_reg.width};
            pcs_pkg::REG_DEPTH:  prdata = {20'd0, cfg_reg.depth};
            pcs_pkg::REG_HEIGHT: prdata = {20'd0, cfg_reg.height};
            default:             prdata = {20'd0, cfg_reg.gap};
        endcase
    end

    assign in_box.x = s_tdata[11:0];
    assign in_box.y = s_tdata[23:12];
    assign in_box.z = s_tdata[35:24];
    assign in_box.w = s_tdata[47:36];
    assign in_box.d = s_tdata[59:48];
    assign in_box.h = s_tdata[71:60];

    assign m_tdata = {8'd0, res.store_full, res.neighbour_found, res.height_gap,
                      res.walls_touched, res.item_area, res.wall_area};

    pcs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pcs_datapath #(.MAX_BOXES(MAX_BOXES)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .in_kind (s_tuser),
        .in_box  (in_box),
        .cfg     (cfg_reg),
        .stat    (stat),
        .res     (res)
    );
endmodule

### rtl/pcs_ctrl.sv
// ---------------------------------------------------------------------------
// pcs_ctrl
// sequencer: accept, wall pass, store scan, result hand-off
// ---------------------------------------------------------------------------
module pcs_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  pcs_pkg::stat_t   stat,
    output pcs_pkg::cmd_t    cmd
);
    pcs_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pcs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            pcs_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load = 1'b1;
                    state_next = pcs_pkg::ST_WALL;
                end
            end
            pcs_pkg::ST_WALL: begin
                if (stat.is_clear) begin
                    cmd.clear = 1'b1;
                    state_next = pcs_pkg::ST_DONE;
                end else if (stat.full) begin
                    cmd.reject = 1'b1;
                    state_next = pcs_pkg::ST_DONE;
                end else begin
                    cmd.wall = 1'b1;
                    state_next = stat.empty ? pcs_pkg::ST_DRAIN : pcs_pkg::ST_SCAN;
                end
            end
            pcs_pkg::ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_last) state_next = pcs_pkg::ST_DRAIN;
            end
            pcs_pkg::ST_DRAIN: begin
                // wait for the last compare to leave the pipeline
                if (!stat.scan_busy) begin
                    cmd.store = 1'b1;
                    state_next = pcs_pkg::ST_DONE;
                end
            end
            pcs_pkg::ST_DONE: begin
                out_valid = 1'b1;
                if (out_ready) state_next = pcs_pkg::ST_IDLE;
            end
            default: state_next = pcs_pkg::ST_IDLE;
        endcase
    end
endmodule

### rtl/pcs_datapath.sv
// ---------------------------------------------------------------------------
// pcs_datapath
// box store, wall scoring and per-box contact / neighbour pipeline
// ---------------------------------------------------------------------------
module pcs_datapath #(
    parameter int MAX_BOXES = pcs_pkg::MAX_BOXES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  pcs_pkg::cmd_t   cmd,
    input  logic            in_kind,
    input  pcs_pkg::box_t   in_box,
    input  pcs_pkg::cfg_t   cfg,
    output pcs_pkg::stat_t  stat,
    output pcs_pkg::res_t   res
);
    localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNTW = $clog2(MAX_BOXES + 1);
    localparam int AREA_W_L = pcs_pkg::AREA_W;

    pcs_pkg::box_t mem [MAX_BOXES];
    pcs_pkg::box_t cur_reg, rd_reg;
    logic kind_reg;
    logic [CNTW-1:0] count_reg, idx_reg;
    logic rd_vld_reg;
    logic [12:0] x2, y2, z2, px2, py2, pz2;
    logic [12:0] ox, oy, oz, gx, gy, diff;
    logic [25:0] px_reg, py_reg, pz_reg;
    logic ex_reg, ey_reg, ez_reg, nb_vld_reg;
    logic [12:0] diff_reg;
    logic acc_vld_reg;
    logic [AREA_W_L-1:0] item_next;
    logic [28:0] item_sum;
    logic [29:0] wall_sum;
    logic [2:0] walls;
    pcs_pkg::res_t res_reg;

    assign x2 = {1'b0, cur_reg.x} + {1'b0, cur_reg.w};
    assign y2 = {1'b0, cur_reg.y} + {1'b0, cur_reg.d};
    assign z2 = {1'b0, cur_reg.z} + {1'b0, cur_reg.h};
    assign px2 = {1'b0, rd_reg.x} + {1'b0, rd_reg.w};
    assign py2 = {1'b0, rd_reg.y} + {1'b0, rd_reg.d};
    assign pz2 = {1'b0, rd_reg.z} + {1'b0, rd_reg.h};

    assign stat.is_clear = (kind_reg == pcs_pkg::KIND_CLEAR);
    assign stat.full = (count_reg >= CNTW'(MAX_BOXES));
    assign stat.empty = (count_reg == '0);
    assign stat.scan_last = (idx_reg == count_reg - CNTW'(1));
    assign stat.scan_busy = rd_vld_reg;
    assign res = res_reg;

    // wall contact terms
    always_comb begin
        logic [23:0] dh, wh, wd;
        dh = cur_reg.d * cur_reg.h;
        wh = cur_reg.w * cur_reg.h;
        wd = cur_reg.w * cur_reg.d;
        wall_sum = '0;
        walls = '0;
        if (cur_reg.x == '0) begin wall_sum = wall_sum + 30'(dh); walls = walls + 3'd1; end
        if (cur_reg.y == '0) begin wall_sum = wall_sum + 30'(wh); walls = walls + 3'd1; end
        if (cur_reg.z == '0) begin wall_sum = wall_sum + 30'(wd); walls = walls + 3'd1; end
        if (x2 == {1'b0, cfg.width}) begin
            wall_sum = wall_sum + 30'(dh); walls = walls + 3'd1;
        end
        if (y2 == {1'b0, cfg.depth}) begin
            wall_sum = wall_sum + 30'(wh); walls = walls + 3'd1;
        end
        if (z2 == {1'b0, cfg.height}) begin
            wall_sum = wall_sum + 30'(wd); walls = walls + 3'd1;
        end
    end

    // per-box overlap and gap
    always_comb begin
        ox = pcs_pkg::ov_len({1'b0, cur_reg.x}, x2, {1'b0, rd_reg.x}, px2);
        oy = pcs_pkg::ov_len({1'b0, cur_reg.y}, y2, {1'b0, rd_reg.y}, py2);
        oz = pcs_pkg::ov_len({1'b0, cur_reg.z}, z2, {1'b0, rd_reg.z}, pz2);
        gx = pcs_pkg::gap_len({1'b0, cur_reg.x}, x2, {1'b0, rd_reg.x}, px2);
        gy = pcs_pkg::gap_len({1'b0, cur_reg.y}, y2, {1'b0, rd_reg.y}, py2);
        diff = (z2 > pz2) ? z2 - pz2 : pz2 - z2;
    end

    // saturating accumulate of registered products
    always_comb begin
        item_sum = {2'b0, res_reg.item_area};
        if (ex_reg) item_sum = item_sum + 29'(px_reg);
        if (ey_reg) item_sum = item_sum + 29'(py_reg);
        if (ez_reg) item_sum = item_sum + 29'(pz_reg);
        item_next = (item_sum > 29'(pcs_pkg::AREA_MAX)) ? pcs_pkg::AREA_MAX
                                                      : item_sum[AREA_W_L-1:0];
    end

    // store write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.store) mem[count_reg[IW-1:0]] <= cur_reg;
        rd_reg <= mem[idx_reg[IW-1:0]];
    end

    // item capture and stage registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_reg <= in_box;
            kind_reg <= in_kind;
        end
        px_reg <= 26'(oy * oz);
        py_reg <= 26'(ox * oz);
        pz_reg <= 26'(ox * oy);
        ex_reg <= (x2 == {1'b0, rd_reg.x}) || (px2 == {1'b0, cur_reg.x});
        ey_reg <= (y2 == {1'b0, rd_reg.y}) || (py2 == {1'b0, cur_reg.y});
        ez_reg <= (z2 == {1'b0, rd_reg.z}) || (pz2 == {1'b0, cur_reg.z});
        nb_vld_reg <= (ox != '0 && gy <= {1'b0, cfg.gap}) ||
                      (oy != '0 && gx <= {1'b0, cfg.gap});
        diff_reg <= diff;
    end

    // control counters, valid chain and result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            idx_reg <= '0;
            rd_vld_reg <= 1'b0;
            acc_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.scan;
            acc_vld_reg <= rd_vld_reg;
            if (cmd.scan) idx_reg <= idx_reg + CNTW'(1);
            if (cmd.load) idx_reg <= '0;
            if (cmd.clear) count_reg <= '0;
            if (cmd.store) count_reg <= count_reg + CNTW'(1);
        end
        // result fields
        if (cmd.load) begin
            res_reg <= '0;
        end else begin
            if (cmd.reject) res_reg.store_full <= 1'b1;
            if (cmd.wall) begin
                res_reg.wall_area <= (wall_sum > 30'(pcs_pkg::AREA_MAX))
                    ? pcs_pkg::AREA_MAX : wall_sum[pcs_pkg::AREA_W-1:0];
                res_reg.walls_touched <= walls;
            end
            if (acc_vld_reg) begin
                res_reg.item_area <= item_next;
                if (nb_vld_reg) begin
                    if (!res_reg.neighbour_found || diff_reg < res_reg.height_gap)
                        res_reg.height_gap <= diff_reg;
                    res_reg.neighbour_found <= 1'b1;
                end
            end
        end
    end
endmodule

### rtl/pcs_checker.sv
// ---------------------------------------------------------------------------
// pcs_checker
// port-level checks of the placement contact scorer
// ---------------------------------------------------------------------------
`include "placement_contact_scorer_core_assert.svh"
module pcs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);
    // one item at a time: no input while a result waits
    `PCS_ASSERT_IMPL(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready)
    // a rejected placement carries only the full flag
    `PCS_ASSERT_IMPL(a_full_clean, aclk, aresetn, m_tvalid && m_tdata[71],
        m_tdata[70:0] == '0)
    // walls touched never above six
    `PCS_ASSERT_IMPL(a_walls, aclk, aresetn, m_tvalid, m_tdata[56:54] <= 3'd6)
    // a stalled result holds
    `PCS_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))
endmodule

bind placement_contact_scorer_core pcs_checker u_pcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
